>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the drop-decision block. Define ASSERT_OFF to strip.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define CODEL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication
`define CODEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Condition that must never hold
`define CODEL_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> !(cond)) \
    else $error("forbidden condition seen");

`else

`define CODEL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CODEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define CODEL_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> design/codel_pkg.sv
// ----------------------------------------------------------------------------
// codel_pkg
// Types and constants shared by the CoDel drop-decision modules.
// ----------------------------------------------------------------------------
`default_nettype none

package codel_pkg;

  // Field widths
  localparam int TIME_W  = 48;
  localparam int COUNT_W = 16;
  localparam int OCC_W   = 9;
  localparam int APB_DW  = 64;
  localparam int APB_AW  = 4;

  // Register decode: one address bit selects between the two registers
  localparam int   REG_SEL_BIT  = 3;
  localparam logic REG_TARGET   = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  // Register reset values
  localparam logic [TIME_W-1:0] TARGET_RESET   = 48'd5000;
  localparam logic [TIME_W-1:0] INTERVAL_RESET = 48'd100000;

  // Inverse square root: 16 fraction bits, so r*r*c is bounded by 2^32
  localparam int                ISR_FRAC  = 16;
  localparam logic [32:0]       ISR_LIMIT = 33'h1_0000_0000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_ROLLBACK = 2'd1,
    CMD_DECIDE   = 2'd2,
    CMD_DEQUEUE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [TIME_W-1:0] now;
  } codel_in_t;

  typedef struct packed {
    logic             drop;
    logic             in_dropping;
    logic [OCC_W-1:0] occupancy;
    status_t          status;
  } codel_out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_JUDGE,
    ST_DECIDE,
    ST_LAW
  } seq_state_t;

  // Control-law unit states
  typedef enum logic [2:0] {
    LAW_IDLE,
    LAW_ROOT,
    LAW_MUL_LO,
    LAW_MUL_HI,
    LAW_SUM,
    LAW_ADD
  } law_state_t;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] count;
  } law_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] next_time;
  } law_rsp_t;

endpackage

`default_nettype wire

>>> design/codel_ram.sv
// ----------------------------------------------------------------------------
// codel_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module codel_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/codel_law.sv
// ----------------------------------------------------------------------------
// codel_law
// Control-law unit: next = base + floor(interval * isr(count) / 2^16).
// isr is found one bit a step with shift/add updates of r*c and r*r*c,
// then the product is built from two 24x16 partial products.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module codel_law
  import codel_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire law_req_t          req,
  input  wire logic [TIME_W-1:0] base,
  input  wire logic [TIME_W-1:0] interval,
  output law_rsp_t               rsp
);

  law_state_t st_r, st_nxt;
  logic       done_r, done_nxt;

  logic [3:0]         bit_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] root_r;
  logic [31:0]        q_r;
  logic [32:0]        p_r;
  logic [TIME_W-1:0]  ivl_r;
  logic [TIME_W-1:0]  base_r;
  logic [39:0]        lo_r;
  logic [39:0]        hi_r;
  logic [63:0]        acc_r;
  logic [TIME_W-1:0]  res_r;

  logic [31:0] q_try;
  logic [49:0] p_try;
  logic        fit;
  logic        take;

  // Trial of the next root bit: (r + 2^k)^2 c = r^2 c + 2^(k+1) r c + 4^k c
  always_comb begin
    q_try = q_r + ({16'd0, cnt_r} << bit_r);
    p_try = 50'(p_r) + (50'(q_r) << ({1'b0, bit_r} + 5'd1))
          + (50'(cnt_r) << {bit_r, 1'b0});
    fit   = (p_try <= 50'(ISR_LIMIT));
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      LAW_IDLE: begin
        if (req.start) begin
          st_nxt = (req.count <= 16'd1) ? LAW_ADD : LAW_ROOT;
        end
      end
      LAW_ROOT: begin
        if (bit_r == 4'd0) begin
          st_nxt = LAW_MUL_LO;
        end
      end
      LAW_MUL_LO: st_nxt = LAW_MUL_HI;
      LAW_MUL_HI: st_nxt = LAW_SUM;
      LAW_SUM:    st_nxt = LAW_ADD;
      LAW_ADD:    st_nxt = LAW_IDLE;
      default:    st_nxt = LAW_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    take     = (st_r == LAW_IDLE) && req.start;
    done_nxt = (st_r == LAW_ADD);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= LAW_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (take) begin
      cnt_r  <= req.count;
      ivl_r  <= interval;
      base_r <= base;
      root_r <= '0;
      q_r    <= '0;
      p_r    <= '0;
      bit_r  <= 4'd15;
      // count 0 or 1 spaces drops by one whole interval
      acc_r  <= {interval, 16'd0};
    end else begin
      unique case (st_r)
        LAW_ROOT: begin
          if (fit) begin
            root_r <= root_r | (16'd1 << bit_r);
            q_r    <= q_try;
            p_r    <= p_try[32:0];
          end
          bit_r <= bit_r - 4'd1;
        end
        LAW_MUL_LO: lo_r  <= 40'(ivl_r[23:0]) * 40'(root_r);
        LAW_MUL_HI: hi_r  <= 40'(ivl_r[47:24]) * 40'(root_r);
        LAW_SUM:    acc_r <= {hi_r, 24'd0} + 64'(lo_r);
        LAW_ADD:    res_r <= base_r + acc_r[63:ISR_FRAC];
        default: begin
        end
      endcase
    end
  end

  assign rsp.done      = done_r;
  assign rsp.next_time = res_r;

  `CODEL_ASSERT_IMPL(a_start_when_idle, clk, rst_n, req.start, st_r == LAW_IDLE)
  `CODEL_ASSERT_NEXT(a_done_single, clk, rst_n, done_r, !done_r)
  `CODEL_ASSERT_NEXT(a_add_gives_done, clk, rst_n, st_r == LAW_ADD, done_r && st_r == LAW_IDLE)

endmodule

`default_nettype wire

>>> design/codel_drop_decision_top.sv
// ----------------------------------------------------------------------------
// codel_drop_decision_top
// CoDel queue-delay controller: timestamp FIFO plus drop-decision sequencer.
// ----------------------------------------------------------------------------
//  Channel   Ports                               Handshake
//  input     start, busy, in_item                beat taken when start && !busy
//  result    out_valid, out_result               one-cycle strobe, never stalled
//  config    psel/penable/pwrite/paddr/pwdata    APB write, pready tied high
//
//  Enqueue, roll back, dequeue and empty-store commands: the result strobe is
//  registered from EXEC, and the next beat can be accepted in that same cycle.
//  Decide with no drop runs EXEC (RAM read), JUDGE and DECIDE; a drop with
//  count 0 or 1 adds LAW for the add step, and a drop with count >= 2 also
//  runs the 16-step inverse square root and two partial products in codel_law.
//  busy is high from the accepting edge until the result strobe.
//  Synchronous active-low reset; the timestamp RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module codel_drop_decision_top
  import codel_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  // input channel
  input  wire logic              start,
  output logic                   busy,
  input  wire codel_in_t         in_item,
  // result channel
  output logic                   out_valid,
  output codel_out_t             out_result
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers
  logic [TIME_W-1:0] target_r;
  logic [TIME_W-1:0] interval_r;

  // Sequencer and queue state
  seq_state_t         state_r, state_nxt;
  cmd_t               cmd_r;
  logic [TIME_W-1:0]  now_r;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [TIME_W-1:0]  first_above_r, first_above_nxt;
  logic [TIME_W-1:0]  dnt_r, dnt_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] last_count_r, last_count_nxt;
  logic               dropping_r, dropping_nxt;
  logic               ok_r, ok_nxt;
  logic               ge_dnt_r, ge_dnt_nxt;
  logic               recent_r, recent_nxt;
  logic               out_valid_r, out_valid_nxt;
  codel_out_t         out_result_r, out_result_nxt;

  // Per-step flags
  logic    finish;
  logic    res_drop;
  status_t res_status;

  // RAM and law unit hookup
  logic               ram_we;
  logic               ram_re;
  logic [TIME_W-1:0]  ram_rdata;
  law_req_t           law_req;
  law_rsp_t           law_rsp;
  logic [TIME_W-1:0]  law_base;

  // Judge and decide terms
  logic [TIME_W-1:0]  sojourn;
  logic               below;
  logic [TIME_W-1:0]  since_dnt;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] delta;
  logic [COUNT_W-1:0] reentry_cnt;
  logic               fifo_empty;
  logic               fifo_full;
  logic               accept;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
  endfunction

  assign accept     = start && !busy;
  assign busy       = (state_r != ST_IDLE);
  assign fifo_empty = (fill_r == '0);
  assign fifo_full  = (fill_r == CNT_W'(QUEUE_DEPTH));

  // ------------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    if (paddr[REG_SEL_BIT] == REG_INTERVAL) begin
      prdata = APB_DW'(interval_r);
    end else begin
      prdata = APB_DW'(target_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= TARGET_RESET;
      interval_r <= INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[REG_SEL_BIT] == REG_INTERVAL) begin
        interval_r <= pwdata[TIME_W-1:0];
      end else begin
        target_r <= pwdata[TIME_W-1:0];
      end
    end
  end

  // ------------------------------------------------------------------------
  // Timestamp store
  // ------------------------------------------------------------------------
  codel_ram #(
    .WIDTH (TIME_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (now_r),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------------------
  // Control-law unit
  // ------------------------------------------------------------------------
  codel_law u_law (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (law_req),
    .base     (law_base),
    .interval (interval_r),
    .rsp      (law_rsp)
  );

  // Judge the head: sojourn against target, first-above and re-entry terms
  always_comb begin
    sojourn    = now_r - ram_rdata;
    below      = (sojourn < target_r) || (fill_r <= CNT_W'(1));
    since_dnt  = now_r - dnt_r;
    ge_dnt_nxt = (now_r >= dnt_r);
    recent_nxt = !ge_dnt_nxt || (52'(since_dnt) < {interval_r, 4'd0});
  end

  // Drop decision and law launch
  always_comb begin
    cnt_inc     = (count_r == COUNT_MAX) ? count_r : count_r + 16'd1;
    delta       = count_r - last_count_r;
    reentry_cnt = ((delta > 16'd1) && recent_r) ? delta : 16'd1;
    law_req     = '0;
    law_base    = now_r;
    if (state_r == ST_DECIDE) begin
      if (dropping_r) begin
        law_req.start = ok_r && ge_dnt_r;
        law_req.count = cnt_inc;
        law_base      = dnt_r;
      end else begin
        law_req.start = ok_r;
        law_req.count = reentry_cnt;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ((cmd_r == CMD_DECIDE) && !fifo_empty) ? ST_JUDGE : ST_IDLE;
      end
      ST_JUDGE:  state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = law_req.start ? ST_LAW : ST_IDLE;
      ST_LAW: begin
        if (law_rsp.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs and state updates
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    fill_nxt        = fill_r;
    first_above_nxt = first_above_r;
    dnt_nxt         = dnt_r;
    count_nxt       = count_r;
    last_count_nxt  = last_count_r;
    dropping_nxt    = dropping_r;
    ok_nxt          = ok_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    finish          = 1'b0;
    res_drop        = 1'b0;
    res_status      = STAT_OK;

    unique case (state_r)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        unique case (cmd_r)
          CMD_ENQUEUE: begin
            finish = 1'b1;
            if (fifo_full) begin
              res_status = STAT_FULL;
            end else begin
              ram_we   = 1'b1;
              tail_nxt = ptr_next(tail_r);
              fill_nxt = fill_r + CNT_W'(1);
            end
          end
          CMD_ROLLBACK: begin
            finish = 1'b1;
            if (fifo_empty) begin
              res_status = STAT_EMPTY;
            end else begin
              tail_nxt = ptr_prev(tail_r);
              fill_nxt = fill_r - CNT_W'(1);
            end
          end
          CMD_DECIDE: begin
            if (fifo_empty) begin
              finish     = 1'b1;
              res_status = STAT_EMPTY;
            end else begin
              ram_re = 1'b1;
            end
          end
          CMD_DEQUEUE: begin
            finish = 1'b1;
            if (fifo_empty) begin
              res_status = STAT_EMPTY;
            end else begin
              head_nxt = ptr_next(head_r);
              fill_nxt = fill_r - CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      ST_JUDGE: begin
        // Track first-above time; ok to drop once it has passed
        ok_nxt = 1'b0;
        if (below) begin
          first_above_nxt = '0;
        end else if (first_above_r == '0) begin
          first_above_nxt = now_r + interval_r;
        end else begin
          ok_nxt = (now_r >= first_above_r);
        end
      end
      ST_DECIDE: begin
        if (dropping_r) begin
          if (!ok_r) begin
            dropping_nxt = 1'b0;
            finish       = 1'b1;
          end else if (ge_dnt_r) begin
            count_nxt = cnt_inc;
          end else begin
            finish = 1'b1;
          end
        end else if (ok_r) begin
          // Enter dropping mode, reusing the recent count when close by
          dropping_nxt   = 1'b1;
          count_nxt      = reentry_cnt;
          last_count_nxt = reentry_cnt;
        end else begin
          finish = 1'b1;
        end
      end
      ST_LAW: begin
        if (law_rsp.done) begin
          dnt_nxt  = law_rsp.next_time;
          finish   = 1'b1;
          res_drop = 1'b1;
        end
      end
      default: begin
      end
    endcase

    out_valid_nxt  = finish;
    out_result_nxt = '{drop:        res_drop,
                       in_dropping: dropping_nxt,
                       occupancy:   OCC_W'(fill_nxt),
                       status:      res_status};
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r        <= '0;
      tail_r        <= '0;
      fill_r        <= '0;
      first_above_r <= '0;
      dnt_r         <= '0;
      count_r       <= '0;
      last_count_r  <= '0;
      dropping_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      fill_r        <= fill_nxt;
      first_above_r <= first_above_nxt;
      dnt_r         <= dnt_nxt;
      count_r       <= count_nxt;
      last_count_r  <= last_count_nxt;
      dropping_r    <= dropping_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers: hold the beat, the judge terms and the result
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item.cmd;
      now_r <= in_item.now;
    end
    if (state_r == ST_JUDGE) begin
      ge_dnt_r <= ge_dnt_nxt;
      recent_r <= recent_nxt;
    end
    ok_r         <= ok_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  `CODEL_ASSERT_NEVER(a_fill_bound, clk, rst_n, fill_r > CNT_W'(QUEUE_DEPTH))
  `CODEL_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  `CODEL_ASSERT_IMPL(a_strobe_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE)
  `CODEL_ASSERT_IMPL(a_drop_in_mode, clk, rst_n, out_valid_r && out_result_r.drop,
                     out_result_r.in_dropping && (out_result_r.status == STAT_OK))

endmodule

`default_nettype wire
